// ----- rtl/rmx_pkg.sv -----
package rmx_pkg;

  localparam int MemBytes = 65536;
  localparam int MemAw = $clog2(MemBytes);

  typedef enum logic [2:0] {
    FN_MWR = 3'd0,
    FN_MRD = 3'd1,
    FN_EXEC = 3'd2,
    FN_RWR = 3'd3,
    FN_RRD = 3'd4
  } func_t;

  localparam logic [3:0] R_AX = 4'd0;
  localparam logic [3:0] R_BX = 4'd3;
  localparam logic [3:0] R_BP = 4'd5;
  localparam logic [3:0] R_SI = 4'd6;
  localparam logic [3:0] R_DI = 4'd7;
  localparam logic [3:0] R_ES = 4'd8;
  localparam logic [3:0] R_CS = 4'd9;
  localparam logic [3:0] R_DS = 4'd11;
  localparam logic [3:0] R_IP = 4'd12;
  localparam logic [3:0] R_NONE = 4'd13;
  localparam int NRegs = 13;

  localparam logic [7:0] OP_ES = 8'h26;
  localparam logic [7:0] OP_CS = 8'h2e;
  localparam logic [7:0] OP_SS = 8'h36;
  localparam logic [7:0] OP_DS = 8'h3e;
  localparam logic [7:0] OP_MOV_ST = 8'h89;
  localparam logic [7:0] OP_MOV_LD = 8'h8b;
  localparam logic [7:0] OP_MOV_IMM8 = 8'hb0;
  localparam logic [7:0] OP_MOV_IMM16 = 8'hb8;
  localparam logic [7:0] OP_INT = 8'hcd;
  localparam logic [7:0] INT_NUM = 8'h21;
  localparam logic [7:0] AH_VER = 8'h30;
  localparam logic [15:0] VER_VAL = 16'h0300;

  typedef enum logic [4:0] {
    S_IDLE, S_MEMRD, S_REGRD, S_OP_A, S_OP_D, S_B1_A, S_B1_D,
    S_B2_A, S_B2_D, S_B3_A, S_B3_D, S_EA, S_D0_A, S_D0_D, S_D1_A, S_D1_D,
    S_W0, S_W1, S_OUT
  } state_t;

  // pointer source for memory address
  typedef enum logic [1:0] {
    AS_ITEM, AS_FETCH, AS_DATA0, AS_DATA1
  } asel_t;

  typedef struct packed {
    logic   mem_we;
    asel_t  asel;
    logic [1:0] fetch_k;
    logic   wbyte_hi;
    logic   ld_op;
    logic   ld_b1;
    logic   ld_b2;
    logic   ld_b3;
    logic   ld_lo;
    logic   ld_ea;
    logic   pfx;
    logic   exec_wb;
    logic   clr_res;
    logic   ld_memrd;
    logic   ld_regrd;
    logic   item_regwr;
    logic   set_ok;
  } cmd_t;

  typedef struct packed {
    logic [7:0] op;
    logic [7:0] b1;
    logic [7:0] mrd;
    logic       ah_ok;
  } sts_t;

  function automatic logic is_pfx(logic [7:0] o);
    return (o == OP_ES) || (o == OP_CS) || (o == OP_SS) || (o == OP_DS);
  endfunction

  function automatic logic [3:0] ea_base(logic [2:0] rm);
    logic [3:0] r;
    unique case (rm)
      3'd0, 3'd1, 3'd7: r = R_BX;
      3'd2, 3'd3, 3'd6: r = R_BP;
      3'd4: r = R_SI;
      default: r = R_DI;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] ea_index(logic [2:0] rm);
    logic [3:0] r;
    unique case (rm)
      3'd0, 3'd2: r = R_SI;
      3'd1, 3'd3: r = R_DI;
      default: r = R_NONE;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/rmx_if.sv -----
interface rmx_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [19:0] mem_addr;
  logic [3:0]  reg_index;
  logic [15:0] wdata;
  modport source (output valid, func, mem_addr, reg_index, wdata, input ready);
  modport sink (input valid, func, mem_addr, reg_index, wdata, output ready);
endinterface

interface rmx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rdata;
  logic        step_ok;
  logic [15:0] next_ip;
  modport source (output valid, rdata, step_ok, next_ip, input ready);
  modport sink (input valid, rdata, step_ok, next_ip, output ready);
endinterface

// ----- rtl/rmx_ram.sv -----
module rmx_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wd,
  output logic [Width-1:0]         rd
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end
endmodule

// ----- rtl/rmx_datapath.sv -----
module rmx_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  rmx_pkg::cmd_t    cmd,
  output rmx_pkg::sts_t    sts,
  input  logic [19:0]      item_addr,
  input  logic [3:0]       item_ri,
  input  logic [15:0]      item_wd,
  output logic [15:0]      res_rdata,
  output logic             res_ok,
  output logic [15:0]      res_ip
);
  import rmx_pkg::*;

  logic [15:0] rf_r [NRegs];
  logic [15:0] seg_r;
  logic [7:0]  op_r, b1_r, b2_r, b3_r, lo_r;
  logic [15:0] off_r;
  logic [15:0] rdata_r;
  logic        ok_r;
  logic [MemAw-1:0] addr;
  logic [7:0]  mrd, mwd;
  logic [15:0] ip, fo, disp;
  logic [19:0] pa;
  logic [1:0]  mod;
  logic [2:0]  regf, rm;

  function automatic logic [15:0] rr(logic [15:0] f [NRegs], logic [3:0] i);
    return (i < 4'(NRegs)) ? f[i] : 16'd0;
  endfunction

  assign ip = rf_r[R_IP];
  assign mod = b1_r[7:6];
  assign regf = b1_r[5:3];
  assign rm = b1_r[2:0];
  assign fo = ip + 16'(cmd.fetch_k);
  assign pa = ({rf_r[R_CS], 4'd0}) + {4'd0, fo};
  logic [19:0] da;
  assign da = {seg_r, 4'd0} + {4'd0, off_r};

  always_comb begin
    unique case (cmd.asel)
      AS_ITEM:  addr = item_addr[MemAw-1:0];
      AS_FETCH: addr = pa[MemAw-1:0];
      AS_DATA0: addr = da[MemAw-1:0];
      default:  addr = da[MemAw-1:0] + MemAw'(1);
    endcase
    if (cmd.asel == AS_ITEM) begin
      mwd = item_wd[7:0];
    end else begin
      mwd = cmd.wbyte_hi ? rf_r[{1'b0, regf}][15:8] : rf_r[{1'b0, regf}][7:0];
    end
  end

  rmx_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk(clk), .we(cmd.mem_we), .addr(addr), .wd(mwd), .rd(mrd)
  );

  always_comb begin
    if (mod == 2'd1) begin
      disp = {{8{b2_r[7]}}, b2_r};
    end else begin
      disp = {b3_r, b2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_op) op_r <= mrd;
    if (cmd.ld_b1) b1_r <= mrd;
    if (cmd.ld_b2) b2_r <= mrd;
    if (cmd.ld_b3) b3_r <= mrd;
    if (cmd.ld_lo) lo_r <= mrd;
    if (cmd.ld_ea) begin
      if (mod == 2'd0 && rm == 3'd6) begin
        off_r <= {b3_r, b2_r};
      end else if (mod == 2'd0) begin
        off_r <= rr(rf_r, ea_base(rm)) + rr(rf_r, ea_index(rm));
      end else begin
        off_r <= rr(rf_r, ea_base(rm)) + rr(rf_r, ea_index(rm)) + disp;
      end
    end
    if (cmd.clr_res) seg_r <= rf_r[R_DS];
    if (cmd.pfx) seg_r <= rf_r[R_ES + {2'd0, mrd[4:3]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NRegs; i++) rf_r[i] <= '0;
      rdata_r <= '0;
      ok_r <= 1'b0;
    end else begin
      if (cmd.clr_res) begin
        rdata_r <= '0;
        ok_r <= 1'b0;
      end
      if (cmd.set_ok) ok_r <= 1'b1;
      if (cmd.ld_memrd) rdata_r <= {8'd0, mrd};
      if (cmd.ld_regrd) rdata_r <= rr(rf_r, item_ri);
      if (cmd.item_regwr && item_ri < 4'(NRegs)) rf_r[item_ri] <= item_wd;
      if (cmd.pfx) rf_r[R_IP] <= ip + 16'd1;
      if (cmd.exec_wb) begin
        priority if (op_r == OP_MOV_LD) begin
          rf_r[{1'b0, regf}] <= {mrd, lo_r};
          rf_r[R_IP] <= ip + ((mod == 2'd1) ? 16'd3 :
            ((mod == 2'd2 || rm == 3'd6) ? 16'd4 : 16'd2));
        end else if (op_r == OP_MOV_ST) begin
          rf_r[R_IP] <= ip + ((mod == 2'd1) ? 16'd3 :
            ((mod == 2'd2 || rm == 3'd6) ? 16'd4 : 16'd2));
        end else if (op_r[7:3] == OP_MOV_IMM8[7:3]) begin
          if (op_r[2]) begin
            rf_r[{2'd0, op_r[1:0]}][15:8] <= b1_r;
          end else begin
            rf_r[{2'd0, op_r[1:0]}][7:0] <= b1_r;
          end
          rf_r[R_IP] <= ip + 16'd2;
        end else if (op_r[7:3] == OP_MOV_IMM16[7:3]) begin
          rf_r[{1'b0, op_r[2:0]}] <= {b2_r, b1_r};
          rf_r[R_IP] <= ip + 16'd3;
        end else begin
          rf_r[R_AX] <= VER_VAL;
          rf_r[R_IP] <= ip + 16'd2;
        end
      end
    end
  end

  logic ah30;
  assign ah30 = rf_r[R_AX][15:8] == AH_VER;

  assign sts.op = op_r;
  assign sts.b1 = b1_r;
  assign sts.mrd = mrd;
  assign sts.ah_ok = ah30;
  assign res_rdata = rdata_r;
  assign res_ok = ok_r;
  assign res_ip = ip;

  always_ff @(posedge clk) begin
    if (rst_n && cmd.exec_wb && op_r == OP_INT) begin
      assert (b1_r == INT_NUM && ah30) else $error("int wb without valid service");
    end
  end

  property p_wr_no_ld;
    @(posedge clk) disable iff (!rst_n) cmd.mem_we |-> !cmd.ld_memrd;
  endproperty
  a_wr_no_ld: assert property (p_wr_no_ld) else $error("write with read load");

  property p_ok_after_wb;
    @(posedge clk) disable iff (!rst_n) cmd.exec_wb |=> ok_r || cmd.clr_res;
  endproperty
  a_ok_after_wb: assert property (p_ok_after_wb) else $error("ok not set");

  property p_pfx_ip;
    @(posedge clk) disable iff (!rst_n) cmd.pfx && !cmd.item_regwr |=> ip == $past(ip) + 16'd1;
  endproperty
  a_pfx_ip: assert property (p_pfx_ip) else $error("prefix ip");
endmodule

// ----- rtl/rmx_ctrl.sv -----
module rmx_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_func,
  output logic             out_valid,
  input  logic             out_ready,
  input  rmx_pkg::sts_t    sts,
  output rmx_pkg::cmd_t    cmd
);
  import rmx_pkg::*;

  state_t state_r, state_nxt;
  logic [16:0] npfx_r, npfx_nxt;
  logic [1:0] mod, mod_d;
  logic [2:0] rm, rm_d;
  logic       ldop, b3need, mov_d;

  assign mod = sts.b1[7:6];
  assign rm = sts.b1[2:0];
  // fields of the byte arriving from memory this cycle
  assign mod_d = sts.mrd[7:6];
  assign rm_d = sts.mrd[2:0];
  assign mov_d = (sts.mrd == OP_MOV_ST) || (sts.mrd == OP_MOV_LD);
  assign ldop = (sts.op == OP_MOV_ST) || (sts.op == OP_MOV_LD);
  assign b3need = (mod == 2'd2) || (mod == 2'd0 && rm == 3'd6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      npfx_r <= '0;
    end else begin
      state_r <= state_nxt;
      npfx_r <= npfx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    npfx_nxt = npfx_r;
    unique case (state_r)
      S_IDLE: begin
        npfx_nxt = '0;
        if (in_valid) begin
          unique case (in_func)
            FN_MRD: state_nxt = S_MEMRD;
            FN_EXEC: state_nxt = S_OP_A;
            FN_RRD: state_nxt = S_REGRD;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_MEMRD, S_REGRD: state_nxt = S_OUT;
      S_OP_A: state_nxt = S_OP_D;
      S_OP_D: begin
        if (is_pfx(sts.mrd)) begin
          if (npfx_r[16]) state_nxt = S_OUT;
          else begin
            npfx_nxt = npfx_r + 17'd1;
            state_nxt = S_OP_A;
          end
        end else if (mov_d || sts.mrd[7:4] == OP_MOV_IMM8[7:4] || sts.mrd == OP_INT) begin
          state_nxt = S_B1_A;
        end else state_nxt = S_OUT;
      end
      S_B1_A: state_nxt = S_B1_D;
      S_B1_D: begin
        if (ldop) state_nxt = (mod_d == 2'd3) ? S_OUT :
          (mod_d == 2'd0 && rm_d != 3'd6) ? S_EA : S_B2_A;
        else if (sts.op[7:3] == OP_MOV_IMM16[7:3]) state_nxt = S_B2_A;
        else state_nxt = S_W1;
      end
      S_B2_A: state_nxt = S_B2_D;
      S_B2_D: state_nxt = (ldop && !b3need) ? S_EA : (ldop ? S_B3_A : S_W1);
      S_B3_A: state_nxt = S_B3_D;
      S_B3_D: state_nxt = S_EA;
      S_EA: state_nxt = (sts.op == OP_MOV_ST) ? S_W0 : S_D0_A;
      S_D0_A: state_nxt = S_D0_D;
      S_D0_D: state_nxt = S_D1_A;
      S_D1_A: state_nxt = S_D1_D;
      S_D1_D: state_nxt = S_OUT;
      S_W0: state_nxt = S_W1;
      S_W1: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.asel = AS_FETCH;
    in_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: begin
        cmd.asel = AS_ITEM;
        if (in_valid) begin
          cmd.clr_res = 1'b1;
          cmd.mem_we = (in_func == FN_MWR);
          cmd.item_regwr = (in_func == FN_RWR);
        end
      end
      S_MEMRD: cmd.ld_memrd = 1'b1;
      S_REGRD: cmd.ld_regrd = 1'b1;
      S_OP_A: cmd.fetch_k = 2'd0;
      S_OP_D: begin
        cmd.ld_op = 1'b1;
        cmd.pfx = is_pfx(sts.mrd) && !npfx_r[16];
      end
      S_B1_A: cmd.fetch_k = 2'd1;
      S_B1_D: cmd.ld_b1 = 1'b1;
      S_B2_A: cmd.fetch_k = 2'd2;
      S_B2_D: cmd.ld_b2 = 1'b1;
      S_B3_A: cmd.fetch_k = 2'd3;
      S_B3_D: cmd.ld_b3 = 1'b1;
      S_EA: cmd.ld_ea = 1'b1;
      S_D0_A: cmd.asel = AS_DATA0;
      S_D0_D: begin
        cmd.asel = AS_DATA0;
        cmd.ld_lo = 1'b1;
      end
      S_D1_A: cmd.asel = AS_DATA1;
      S_D1_D: begin
        cmd.asel = AS_DATA1;
        cmd.exec_wb = 1'b1;
        cmd.set_ok = 1'b1;
      end
      S_W0: begin
        cmd.asel = AS_DATA0;
        cmd.mem_we = 1'b1;
      end
      S_W1: begin
        if (sts.op == OP_MOV_ST) begin
          cmd.asel = AS_DATA1;
          cmd.mem_we = 1'b1;
          cmd.wbyte_hi = 1'b1;
          cmd.exec_wb = 1'b1;
          cmd.set_ok = 1'b1;
        end else if (sts.op != OP_INT ||
            (sts.b1 == INT_NUM && sts.ah_ok)) begin
          cmd.exec_wb = 1'b1;
          cmd.set_ok = 1'b1;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  property p_excl;
    @(posedge clk) disable iff (!rst_n) !(in_ready && out_valid);
  endproperty
  a_excl: assert property (p_excl) else $error("busy overlap");

  property p_pfx_cap;
    @(posedge clk) disable iff (!rst_n) npfx_r <= 17'd65536;
  endproperty
  a_pfx_cap: assert property (p_pfx_cap) else $error("prefix count");
endmodule

// ----- rtl/real_mode_mov_subset_executor_core.sv -----
// execute time is set by byte fetches over the single memory port, and each prefix
// adds another opcode fetch
// one item at a time: the next word is accepted the cycle after the result is taken
// synchronous active-low reset clears registers and control; memory is not cleared
module real_mode_mov_subset_executor_core (
  input logic clk,
  input logic rst_n,
  rmx_in_if.sink    in_ch,
  rmx_out_if.source out_ch
);
  import rmx_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [2:0]  func_r;
  logic [19:0] addr_r;
  logic [3:0]  ri_r;
  logic [15:0] wd_r;
  logic [1:0]  ah_dummy;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      addr_r <= in_ch.mem_addr;
      ri_r <= in_ch.reg_index;
      wd_r <= in_ch.wdata;
    end
  end
  assign ah_dummy = func_r[1:0];

  rmx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_func(in_ch.func), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  rmx_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .item_addr(in_ch.ready ? in_ch.mem_addr : addr_r),
    .item_ri(in_ch.ready ? in_ch.reg_index : ri_r),
    .item_wd(in_ch.ready ? in_ch.wdata : wd_r),
    .res_rdata(out_ch.rdata), .res_ok(out_ch.step_ok), .res_ip(out_ch.next_ip)
  );

  property p_func_reg;
    @(posedge clk) disable iff (!rst_n) out_ch.valid |-> !in_ch.ready;
  endproperty
  a_func_reg: assert property (p_func_reg) else $error("ready while result pending");

  property p_hold_item;
    @(posedge clk) disable iff (!rst_n) !in_ch.ready |=> $stable(ah_dummy) || in_ch.ready;
  endproperty
  a_hold_item: assert property (p_hold_item) else $error("item reg changed");

  property p_step_ok;
    @(posedge clk) disable iff (!rst_n) out_ch.valid && out_ch.step_ok |-> func_r == FN_EXEC;
  endproperty
  a_step_ok: assert property (p_step_ok) else $error("ok on non execute");
endmodule

// ----- tb/real_mode_mov_subset_executor_core_test.sv -----
module real_mode_mov_subset_executor_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rmx_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int TargetWords = 650;

  typedef struct {
    logic [15:0] rdata;
    logic        step_ok;
    logic [15:0] next_ip;
  } result_t;

  class cpu_scoreboard;
    logic [7:0]  mem [MemBytes];
    bit          written [MemBytes];
    logic [15:0] regs [14];
    logic [15:0] missing [$];
    result_t     pending [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (written[i]) written[i] = 1'b0;
      errors = 0;
    endfunction

    function logic [15:0] phys(logic [15:0] seg, logic [15:0] off);
      logic [19:0] sum;
      sum = {seg, 4'h0} + {4'h0, off};
      return sum[15:0];
    endfunction

    function logic [7:0] rd_byte(logic [15:0] a);
      if (!written[a]) missing.push_back(a);
      return mem[a];
    endfunction

    // commit=0 only records bytes touched before being written
    function bit run_exec(bit commit);
      logic [15:0] r [14];
      logic [15:0] seg, off, len, a, sv;
      logic [7:0]  op, modrm, d;
      logic [2:0]  rm, rg;
      logic [1:0]  md;
      int          n;
      bit          ok, st;
      foreach (regs[i]) r[i] = regs[i];
      r[R_NONE] = '0;
      seg = r[R_DS];
      n = 0;
      ok = 1'b0;
      st = 1'b0;
      op = rd_byte(phys(r[R_CS], r[R_IP]));
      while (is_pfx_byte(op) && n < 65536) begin
        n++;
        seg = r[int'(R_ES) + op[4:3]];
        r[R_IP] = r[R_IP] + 16'd1;
        op = rd_byte(phys(r[R_CS], r[R_IP]));
      end
      if (is_pfx_byte(op)) begin
        ok = 1'b0;
      end else if (op == OP_MOV_ST || op == OP_MOV_LD) begin
        modrm = rd_byte(phys(r[R_CS], r[R_IP] + 16'd1));
        md = modrm[7:6];
        rg = modrm[5:3];
        rm = modrm[2:0];
        if (md != 2'd3) begin
          off = r[base_reg(rm)] + r[index_reg(rm)];
          len = 16'd2;
          if (md == 2'd0 && rm == 3'd6) begin
            off = {rd_byte(phys(r[R_CS], r[R_IP] + 16'd3)),
                   rd_byte(phys(r[R_CS], r[R_IP] + 16'd2))};
            len = 16'd4;
          end else if (md == 2'd1) begin
            d = rd_byte(phys(r[R_CS], r[R_IP] + 16'd2));
            off = off + {{8{d[7]}}, d};
            len = 16'd3;
          end else if (md == 2'd2) begin
            off = off + {rd_byte(phys(r[R_CS], r[R_IP] + 16'd3)),
                         rd_byte(phys(r[R_CS], r[R_IP] + 16'd2))};
            len = 16'd4;
          end
          a = phys(seg, off);
          if (op == OP_MOV_ST) begin
            st = 1'b1;
            sv = r[rg];
          end else begin
            r[rg] = {rd_byte(a + 16'd1), rd_byte(a)};
          end
          r[R_IP] = r[R_IP] + len;
          ok = 1'b1;
        end
      end else if (op[7:3] == OP_MOV_IMM8[7:3]) begin
        d = rd_byte(phys(r[R_CS], r[R_IP] + 16'd1));
        if (op[2]) r[op[1:0]][15:8] = d;
        else r[op[1:0]][7:0] = d;
        r[R_IP] = r[R_IP] + 16'd2;
        ok = 1'b1;
      end else if (op[7:3] == OP_MOV_IMM16[7:3]) begin
        r[op[2:0]] = {rd_byte(phys(r[R_CS], r[R_IP] + 16'd2)),
                      rd_byte(phys(r[R_CS], r[R_IP] + 16'd1))};
        r[R_IP] = r[R_IP] + 16'd3;
        ok = 1'b1;
      end else if (op == OP_INT) begin
        if (rd_byte(phys(r[R_CS], r[R_IP] + 16'd1)) == INT_NUM && r[R_AX][15:8] == AH_VER) begin
          r[R_AX] = VER_VAL;
          r[R_IP] = r[R_IP] + 16'd2;
          ok = 1'b1;
        end
      end
      // failing opcode still keeps ip moved past the prefixes
      if (!ok) for (int i = 0; i < NRegs; i++) if (i != int'(R_IP)) r[i] = regs[i];
      if (commit) begin
        for (int i = 0; i < NRegs; i++) regs[i] = r[i];
        if (st) begin
          mem[a] = sv[7:0];
          mem[a + 16'd1] = sv[15:8];
          written[a] = 1'b1;
          written[a + 16'd1] = 1'b1;
        end
      end
      return ok;
    endfunction

    function bit is_pfx_byte(logic [7:0] o);
      return o == OP_ES || o == OP_CS || o == OP_SS || o == OP_DS;
    endfunction

    function int base_reg(logic [2:0] rm);
      case (rm)
        3'd0, 3'd1, 3'd7: return int'(R_BX);
        3'd2, 3'd3, 3'd6: return int'(R_BP);
        3'd4: return int'(R_SI);
        default: return int'(R_DI);
      endcase
    endfunction

    function int index_reg(logic [2:0] rm);
      case (rm)
        3'd0, 3'd2: return int'(R_SI);
        3'd1, 3'd3: return int'(R_DI);
        default: return int'(R_NONE);
      endcase
    endfunction

    function void note_input(func_t f, logic [19:0] addr, logic [3:0] ri, logic [15:0] wd);
      result_t res;
      res.rdata = '0;
      res.step_ok = 1'b0;
      case (f)
        FN_MWR: begin
          mem[addr[15:0]] = wd[7:0];
          written[addr[15:0]] = 1'b1;
        end
        FN_MRD: res.rdata = {8'h00, mem[addr[15:0]]};
        FN_EXEC: res.step_ok = run_exec(1'b1);
        FN_RWR: if (ri < NRegs) regs[ri] = wd;
        FN_RRD: if (ri < NRegs) res.rdata = regs[ri];
        default: ;
      endcase
      res.next_ip = regs[R_IP];
      pending.push_back(res);
    endfunction

    function void check_result(logic [15:0] rdata, logic step_ok, logic [15:0] next_ip);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word rdata=%h step_ok=%b next_ip=%h",
                 $time, rdata, step_ok, next_ip);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rdata !== e.rdata) begin
        $display("%0t: rdata expected %h actual %h", $time, e.rdata, rdata);
        errors++;
      end
      if (step_ok !== e.step_ok) begin
        $display("%0t: step_ok expected %b actual %b", $time, e.step_ok, step_ok);
        errors++;
      end
      if (next_ip !== e.next_ip) begin
        $display("%0t: next_ip expected %h actual %h", $time, e.next_ip, next_ip);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rmx_in_if in_ch ();
  rmx_out_if out_ch ();
  cpu_scoreboard sb;
  int n_in;
  int send_idle;
  int recv_stall;
  int idle_cycles;

  real_mode_mov_subset_executor_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.rdata, out_ch.step_ok, out_ch.next_ip);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("real_mode_mov_subset_executor_core regression: fail");
      $finish;
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  task automatic send(func_t f, logic [19:0] addr, logic [3:0] ri, logic [15:0] wd);
    case ((n_in / 80) % 4)
      0: begin send_idle = 0; recv_stall = 0; end
      1: begin send_idle = 47; recv_stall = 0; end
      2: begin send_idle = 0; recv_stall = 47; end
      default: begin send_idle = 23; recv_stall = 23; end
    endcase
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.mem_addr <= addr;
    in_ch.reg_index <= ri;
    in_ch.wdata <= wd;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(f, addr, ri, wd);
    n_in++;
  endtask

  // lays down one instruction at cs:ip, fills any data it touches, then runs it
  task automatic run_instr(int kind);
    logic [7:0]  code [$];
    logic [7:0]  pfx [4];
    logic [7:0]  modrm;
    logic [15:0] cs, ip;
    pfx = '{OP_ES, OP_CS, OP_SS, OP_DS};
    repeat ($urandom_range(0, 3)) code.push_back(pfx[$urandom_range(0, 3)]);
    case (kind)
      0, 1: begin
        code.push_back(kind == 0 ? OP_MOV_ST : OP_MOV_LD);
        modrm = 8'($urandom_range(0, 255));
        if (modrm[7:6] == 2'd3 && $urandom_range(3) != 0) modrm[7:6] = 2'($urandom_range(0, 2));
        code.push_back(modrm);
        code.push_back(8'($urandom_range(0, 255)));
        code.push_back(8'($urandom_range(0, 255)));
      end
      2: begin
        code.push_back(OP_MOV_IMM8 + 8'($urandom_range(0, 7)));
        code.push_back(8'($urandom_range(0, 255)));
      end
      3: begin
        code.push_back(OP_MOV_IMM16 + 8'($urandom_range(0, 7)));
        code.push_back(8'($urandom_range(0, 255)));
        code.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        if ($urandom_range(3) != 0)
          send(FN_RWR, 20'($urandom), R_AX, {AH_VER, 8'($urandom_range(0, 255))});
        code.push_back(OP_INT);
        code.push_back($urandom_range(3) != 0 ? INT_NUM : 8'($urandom_range(0, 255)));
      end
      default: code.push_back(8'($urandom_range(0, 255)));
    endcase
    cs = sb.regs[R_CS];
    ip = sb.regs[R_IP];
    foreach (code[k])
      send(FN_MWR, {4'($urandom), sb.phys(cs, ip + 16'(k))}, 4'($urandom),
           {8'($urandom), code[k]});
    forever begin
      sb.missing.delete();
      void'(sb.run_exec(1'b0));
      if (sb.missing.size() == 0) break;
      send(FN_MWR, {4'($urandom), sb.missing[0]}, 4'($urandom), 16'($urandom));
    end
    send(FN_EXEC, 20'($urandom), 4'($urandom), 16'($urandom));
  endtask

  task automatic random_word();
    logic [15:0] a;
    case ($urandom_range(0, 9))
      0, 1: send(FN_MWR, 20'($urandom), 4'($urandom), 16'($urandom));
      2: begin
        do a = 16'($urandom); while (!sb.written[a] && $urandom_range(50) != 0);
        if (sb.written[a]) send(FN_MRD, {4'($urandom), a}, 4'($urandom), 16'($urandom));
      end
      3, 4: send(FN_RWR, 20'($urandom), 4'($urandom_range(0, 12)),
                 $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 15)));
      default: send(FN_RRD, 20'($urandom), 4'($urandom_range(0, 12)), 16'($urandom));
    endcase
  endtask

  initial begin
    sb = new();
    n_in = 0;
    send_idle = 0;
    recv_stall = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_MWR;
    in_ch.mem_addr = '0;
    in_ch.reg_index = '0;
    in_ch.wdata = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(FN_RRD, '0, R_IP, '0);
    send(FN_MWR, 20'hfffff, 4'hf, 16'hffff);
    send(FN_MRD, 20'h0ffff, '0, '0);
    send(FN_MWR, '0, '0, '0);
    send(FN_MRD, 20'hf0000, '0, 16'hffff);
    send(FN_RWR, '0, R_IP, 16'hfffe);
    send(FN_RWR, '0, R_CS, 16'hffff);
    for (int k = 0; k < 6; k++) run_instr(k);
    send(FN_RWR, '0, R_DS, 16'h0000);
    send(FN_RWR, '0, R_IP, 16'h0000);

    while (n_in < TargetWords) begin
      if ($urandom_range(99) < 55) run_instr($urandom_range(0, 5));
      else random_word();
    end
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("real_mode_mov_subset_executor_core regression: pass");
    else $display("real_mode_mov_subset_executor_core regression: fail");
    $finish;
  end
endmodule
